// ===== sv/teav_pkg.sv =====
`timescale 1ns / 1ps
package teav_pkg;

  localparam int DATA_W         = 32;
  localparam int KEY_CNT        = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int ROUNDS_DEFAULT = 32;
  localparam int SHIFT_L        = 4;
  localparam int SHIFT_R        = 5;

  localparam logic [DATA_W-1:0] DELTA_RESET = 32'h9E3779B9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_A = 3'd0,
    CFG_KEY_B = 3'd1,
    CFG_KEY_C = 3'd2,
    CFG_KEY_D = 3'd3,
    CFG_DELTA = 3'd4
  } teav_cfg_e;

  typedef logic [KEY_CNT-1:0][DATA_W-1:0] teav_key_t;

  // One block in flight: operation, both words and the running sum
  typedef struct packed {
    logic              action;
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    logic [DATA_W-1:0] sum;
  } teav_blk_t;

  // First term of the mix: ((v << 4) + ka) ^ v
  function automatic logic [DATA_W-1:0] teav_mix_shl(logic [DATA_W-1:0] v,
                                                     logic [DATA_W-1:0] ka);
    logic [DATA_W-1:0] t;
    t = (v << SHIFT_L) + ka;
    return t ^ v;
  endfunction

  // Second term of the mix: (sum ^ (v >> 5)) + kb
  function automatic logic [DATA_W-1:0] teav_mix_shr(logic [DATA_W-1:0] v,
                                                     logic [DATA_W-1:0] sum,
                                                     logic [DATA_W-1:0] kb);
    return (sum ^ (v >> SHIFT_R)) + kb;
  endfunction

endpackage

// ===== sv/teav_round.sv =====
`timescale 1ns / 1ps
module teav_round (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  teav_pkg::teav_blk_t        blk_i,
  input  teav_pkg::teav_key_t        key_i,
  input  logic [teav_pkg::DATA_W-1:0] delta_i,
  output logic                       valid_o,
  output teav_pkg::teav_blk_t        blk_o
);
  import teav_pkg::*;

  // First half: mix terms, then fold into the target word
  logic              h1a_valid_q;
  teav_blk_t         h1a_blk_q, h1a_blk_d;
  logic [DATA_W-1:0] h1a_t1_q, h1a_t1_d;
  logic [DATA_W-1:0] h1a_t2_q, h1a_t2_d;
  logic              h1b_valid_q;
  teav_blk_t         h1b_blk_q, h1b_blk_d;
  // Second half
  logic              h2a_valid_q;
  teav_blk_t         h2a_blk_q, h2a_blk_d;
  logic [DATA_W-1:0] h2a_t1_q, h2a_t1_d;
  logic [DATA_W-1:0] h2a_t2_q, h2a_t2_d;
  logic              h2b_valid_q;
  teav_blk_t         h2b_blk_q, h2b_blk_d;

  logic [DATA_W-1:0] v1, ka1, kb1, f1;
  logic [DATA_W-1:0] v2, ka2, kb2, f2;

  // Encrypt mixes right into left first; decrypt mixes left into right first
  always_comb begin
    h1a_blk_d = blk_i;
    if (blk_i.action) begin
      v1  = blk_i.left;
      ka1 = key_i[2];
      kb1 = key_i[3];
    end else begin
      v1  = blk_i.right;
      ka1 = key_i[0];
      kb1 = key_i[1];
    end
    h1a_t1_d = teav_mix_shl(v1, ka1);
    h1a_t2_d = teav_mix_shr(v1, blk_i.sum, kb1);
  end

  always_comb begin
    h1b_blk_d = h1a_blk_q;
    f1        = h1a_t1_q + h1a_t2_q;
    if (h1a_blk_q.action) begin
      h1b_blk_d.right = h1a_blk_q.right - f1;
    end else begin
      h1b_blk_d.left = h1a_blk_q.left + f1;
    end
  end

  always_comb begin
    h2a_blk_d = h1b_blk_q;
    if (h1b_blk_q.action) begin
      v2  = h1b_blk_q.right;
      ka2 = key_i[0];
      kb2 = key_i[1];
    end else begin
      v2  = h1b_blk_q.left;
      ka2 = key_i[2];
      kb2 = key_i[3];
    end
    h2a_t1_d = teav_mix_shl(v2, ka2);
    h2a_t2_d = teav_mix_shr(v2, h1b_blk_q.sum, kb2);
  end

  // Fold the second half and step the sum for the next round
  always_comb begin
    h2b_blk_d = h2a_blk_q;
    f2        = h2a_t1_q + h2a_t2_q;
    if (h2a_blk_q.action) begin
      h2b_blk_d.left = h2a_blk_q.left - f2;
      h2b_blk_d.sum  = h2a_blk_q.sum - delta_i;
    end else begin
      h2b_blk_d.right = h2a_blk_q.right + f2;
      h2b_blk_d.sum   = h2a_blk_q.sum + delta_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1a_valid_q <= 1'b0;
      h1b_valid_q <= 1'b0;
      h2a_valid_q <= 1'b0;
      h2b_valid_q <= 1'b0;
    end else if (en_i) begin
      h1a_valid_q <= valid_i;
      h1b_valid_q <= h1a_valid_q;
      h2a_valid_q <= h1b_valid_q;
      h2b_valid_q <= h2a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1a_blk_q <= h1a_blk_d;
      h1a_t1_q  <= h1a_t1_d;
      h1a_t2_q  <= h1a_t2_d;
      h1b_blk_q <= h1b_blk_d;
      h2a_blk_q <= h2a_blk_d;
      h2a_t1_q  <= h2a_t1_d;
      h2a_t2_q  <= h2a_t2_d;
      h2b_blk_q <= h2b_blk_d;
    end
  end

  assign valid_o = h2b_valid_q;
  assign blk_o   = h2b_blk_q;

endmodule

// ===== sv/tea_variant_block_cipher_core.sv =====
`timescale 1ns / 1ps
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+---------------------------------
// in       | input     | in_valid_i/in_stall_o | action_i, left_in_i, right_in_i
// out      | output    | out_valid_o/out_stall_i | left_out_o, right_out_o
// cfg      | input     | cfg_we_i              | cfg_idx_i, cfg_wdata_i
//
// One block per cycle while in_stall_o is low. Each round is four register
// stages (mix terms and fold, twice), and an output register follows the last round.
// Reset clears all valid bits, the key words to zero and the delta to its
// default. An output stall lets one more block drain into a skid register;
// the whole round pipeline then holds and in_stall_o stays high until the
// output transfers.
module tea_variant_block_cipher_core #(
  parameter int ROUNDS = teav_pkg::ROUNDS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [teav_pkg::DATA_W-1:0]    left_in_i,
  input  logic [teav_pkg::DATA_W-1:0]    right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [teav_pkg::DATA_W-1:0]    left_out_o,
  output logic [teav_pkg::DATA_W-1:0]    right_out_o,
  input  logic                          cfg_we_i,
  input  logic [teav_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [teav_pkg::DATA_W-1:0]    cfg_wdata_i
);
  import teav_pkg::*;

  localparam logic [2*DATA_W-1:0] DecStartWide =
    (2*DATA_W)'(DELTA_RESET) * (2*DATA_W)'(ROUNDS);
  localparam logic [DATA_W-1:0] DecStartReset = DecStartWide[DATA_W-1:0];
  localparam logic [DATA_W-1:0] RoundsW       = DATA_W'(ROUNDS);

  teav_key_t         key_q;
  logic [DATA_W-1:0] delta_q;
  logic [DATA_W-1:0] dec_start_q, dec_start_d;

  logic              pipe_en;
  logic [ROUNDS:0]   chain_valid;
  teav_blk_t         chain_blk [0:ROUNDS];

  logic              out_valid_q;
  logic [DATA_W-1:0] out_left_q, out_right_q;
  logic              skid_valid_q;
  logic [DATA_W-1:0] skid_left_q, skid_right_q;
  logic              out_free, pipe_fire;

  // Decrypt starts from delta*ROUNDS; keep it alongside the delta
  assign dec_start_d = cfg_wdata_i * RoundsW;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      delta_q     <= DELTA_RESET;
      dec_start_q <= DecStartReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KEY_A: key_q[0] <= cfg_wdata_i;
        CFG_KEY_B: key_q[1] <= cfg_wdata_i;
        CFG_KEY_C: key_q[2] <= cfg_wdata_i;
        CFG_KEY_D: key_q[3] <= cfg_wdata_i;
        CFG_DELTA: begin
          delta_q     <= cfg_wdata_i;
          dec_start_q <= dec_start_d;
        end
        default: ;
      endcase
    end
  end

  // Pipeline advances whenever the skid register is empty
  assign pipe_en    = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  assign chain_valid[0]       = in_valid_i;
  assign chain_blk[0].action = action_i;
  assign chain_blk[0].left   = left_in_i;
  assign chain_blk[0].right  = right_in_i;
  assign chain_blk[0].sum    = action_i ? dec_start_q : delta_q;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    teav_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (chain_valid[r]),
      .blk_i   (chain_blk[r]),
      .key_i   (key_q),
      .delta_i (delta_q),
      .valid_o (chain_valid[r+1]),
      .blk_o   (chain_blk[r+1])
    );
  end

  assign out_free  = !out_valid_q || !out_stall_i;
  assign pipe_fire = chain_valid[ROUNDS] && pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || pipe_fire;
      skid_valid_q <= 1'b0;
    end else if (pipe_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_left_q  <= skid_left_q;
        out_right_q <= skid_right_q;
      end else if (pipe_fire) begin
        out_left_q  <= chain_blk[ROUNDS].left;
        out_right_q <= chain_blk[ROUNDS].right;
      end
    end else if (pipe_fire) begin
      // hold the finished block while the output is stalled
      skid_left_q  <= chain_blk[ROUNDS].left;
      skid_right_q <= chain_blk[ROUNDS].right;
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_left_q;
  assign right_out_o = out_right_q;

endmodule

// ===== sv/teav_checker.sv =====
`timescale 1ns / 1ps
module teav_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [teav_pkg::DATA_W-1:0] left_out_o,
  input logic [teav_pkg::DATA_W-1:0] right_out_o
);
  import teav_pkg::*;

  // Input backpressure only comes from a result already waiting
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result on the output");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall rose without a stalled output");

  // Once the output drains, the skid is empty in the following cycle
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("input stall held after output transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(left_out_o) && $stable(right_out_o))
    else $error("stalled result changed");

endmodule

bind tea_variant_block_cipher_core teav_checker u_teav_checker (.*);
